FILE: rtl/abdsl_pkg.sv
// ============================================================================
// abdsl_pkg
// Types, address map and sound latch tables of the bus decoder core.
// ============================================================================
package abdsl_pkg;

    // Access kinds carried in s_tuser
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // Address map
    localparam logic [15:0] ADDR_RAM_LO  = 16'h6000;
    localparam logic [15:0] ADDR_RAM_HI  = 16'h7000;
    localparam logic [15:0] ADDR_VRAM_LO = 16'h7400;
    localparam logic [15:0] ADDR_VRAM_HI = 16'h7800;
    localparam logic [15:0] ADDR_LATCH   = 16'h7c00;
    localparam logic [15:0] ADDR_PORT2   = 16'h7c80;
    localparam logic [15:0] ADDR_SYSTEM  = 16'h7d00;
    localparam logic [15:0] ADDR_JUMP    = 16'h7d01;
    localparam logic [15:0] ADDR_BOOM    = 16'h7d02;
    localparam logic [15:0] ADDR_SPRING  = 16'h7d03;
    localparam logic [15:0] ADDR_FALL    = 16'h7d04;
    localparam logic [15:0] ADDR_SCORE   = 16'h7d05;
    localparam logic [15:0] ADDR_DIP     = 16'h7d80;
    localparam logic [15:0] ADDR_IRQ     = 16'h7d84;

    // Work RAM window size; the RAM mirrors inside it
    localparam int RAM_WINDOW = 4096;

    // Video RAM is fixed in size
    localparam int VRAM_DEPTH = 1024;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);

    // Configuration port
    localparam int          CFG_AW           = 3;
    localparam logic        CFG_DIP_SWITCHES = 1'b0;
    localparam logic [7:0]  DIP_RESET        = 8'h80;

    // Effect codes
    localparam logic [2:0] FX_NONE   = 3'd0;
    localparam logic [2:0] FX_BOOM   = 3'd1;
    localparam logic [2:0] FX_HAMMER = 3'd2;
    localparam logic [2:0] FX_JUMP   = 3'd3;
    localparam logic [2:0] FX_SPRING = 3'd4;
    localparam logic [2:0] FX_FALL   = 3'd5;
    localparam logic [2:0] FX_SCORE  = 3'd6;
    localparam logic [2:0] FX_RIVET  = 3'd7;

    // Tune codes that the control logic looks at
    localparam logic [3:0] TUNE_NONE    = 4'd0;
    localparam logic [3:0] TUNE_DEATH   = 4'd3;
    localparam logic [3:0] TUNE_LOWTIME = 4'd8;

    // Sound latch values with a special meaning
    localparam logic [7:0] LATCH_STOP   = 8'd0;
    localparam logic [7:0] LATCH_HAMMER = 8'd6;
    localparam logic [7:0] LATCH_RIVET  = 8'd13;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RD_ROM,
        OP_RD_RAM,
        OP_RD_VRAM,
        OP_RD_PORT1,
        OP_RD_PORT2,
        OP_RD_SYSTEM,
        OP_RD_DIP,
        OP_WR_RAM,
        OP_WR_VRAM,
        OP_WR_LATCH,
        OP_WR_JUMP,
        OP_WR_BOOM,
        OP_WR_SPRING,
        OP_WR_FALL,
        OP_WR_SCORE,
        OP_WR_DEATH,
        OP_WR_IRQ,
        OP_LD_ROM
    } op_t;

    typedef struct packed {
        logic [2:0] effect;
        logic [3:0] tune;
        logic       tune_loop;
        logic       irq;
    } snd_res_t;

    // Sound latch value to tune number, zero where the value is no tune
    function automatic logic [3:0] latch_tune(input logic [7:0] data);
        logic [3:0] t;
        unique case (data)
            8'd1:    t = 4'd1;
            8'd2:    t = 4'd2;
            8'd3:    t = 4'd8;
            8'd4:    t = 4'd9;
            8'd5:    t = 4'd12;
            8'd7:    t = 4'd10;
            8'd8:    t = 4'd4;
            8'd9:    t = 4'd5;
            8'd10:   t = 4'd6;
            8'd11:   t = 4'd7;
            8'd12:   t = 4'd11;
            8'd14:   t = 4'd13;
            default: t = TUNE_NONE;
        endcase
        return t;
    endfunction

    // Tunes that loop: the stage tunes
    function automatic logic tune_repeats(input logic [3:0] tune);
        return (tune >= 4'd4) && (tune <= 4'd9);
    endfunction

endpackage

FILE: rtl/arcade_bus_decoder_sound_latch_core.sv
// ============================================================================
// arcade_bus_decoder_sound_latch_core
// CPU bus decoder with program ROM, work RAM, video RAM and sound latch.
// ============================================================================
// Usage:
//   One bus access is one item on the s_ channel: s_tuser carries the mode
//   (read, write, ROM preload), s_tdata the address, write byte and the
//   three input ports. Every item gives one result on the m_ channel:
//   the read byte, any effect or tune newly started, and the current vblank
//   interrupt enable.
//   Memory read, write or preload happens at the edge that accepts the item;
//   the registered memory output and the latched item feed the sound and
//   read logic, whose result lands in the output register. m_tvalid rises
//   when the access stage moves into the output register, which waits while
//   a result is held; one item is accepted per cycle unless the output stalls.
//   A stalled m_tready holds the result; one more item is taken into the
//   internal stage, after which s_tready drops until the result is taken.
//   After reset the work RAM and video RAM are cleared, one entry a cycle,
//   over RAM_DEPTH entries; s_tready stays low during that pass. Program ROM
//   keeps its contents over reset and must be preloaded before it is read.
//   The DIP switch register (APB offset 0) resets to 0x80.
// ============================================================================
module arcade_bus_decoder_sound_latch_core
    import abdsl_pkg::*;
#(
    parameter int ROM_DEPTH = 16384,
    parameter int RAM_DEPTH = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    // s_tdata: address[15:0], write_data[23:16], player_port[28:24],
    //          second_port[36:29], system_port[44:37], zero fill
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,
    // s_tuser: mode[1:0]
    input  logic [1:0]        s_tuser,
    // m_tdata: read_data[7:0], effect_start[10:8], tune_start[14:11],
    //          tune_loop[15], vblank_irq_enable[16], zero fill
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int ROM_AW = $clog2(ROM_DEPTH);
    localparam int RAM_AW = $clog2(RAM_DEPTH);

    // ------------------------------------------------------------------ APB
    logic [7:0] dip_reg;
    logic       cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[CFG_AW-1:2] == CFG_DIP_SWITCHES;
    assign prdata  = cfg_sel ? {24'd0, dip_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_reg <= DIP_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            dip_reg <= pwdata[7:0];
        end
    end

    // ------------------------------------------------------- clearing pass
    logic              clr_reg;
    logic [RAM_AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clr_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == RAM_AW'(RAM_DEPTH - 1)) begin
                clr_reg <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------- input decode
    logic               accept;
    op_t                in_op;
    logic [ROM_AW-1:0]  rom_idx;
    logic [RAM_AW-1:0]  ram_idx;
    logic [VRAM_AW-1:0] vram_idx;
    logic [7:0]         in_wdata;

    assign accept   = s_tvalid && s_tready;
    assign in_wdata = s_tdata[23:16];

    abdsl_decode #(
        .ROM_DEPTH (ROM_DEPTH),
        .RAM_DEPTH (RAM_DEPTH)
    ) u_decode (
        .mode     (s_tuser),
        .address  (s_tdata[15:0]),
        .op       (in_op),
        .rom_idx  (rom_idx),
        .ram_idx  (ram_idx),
        .vram_idx (vram_idx)
    );

    // ------------------------------------------------------------- memories
    logic [7:0]         rom_rdata, ram_rdata, vram_rdata;
    logic               ram_we, vram_we;
    logic [RAM_AW-1:0]  ram_addr;
    logic [VRAM_AW-1:0] vram_addr;
    logic [7:0]         ram_wdata, vram_wdata;
    logic               vram_clr;

    // video RAM is cleared by the first VRAM_DEPTH steps of the pass
    assign vram_clr = clr_reg && ((clr_cnt_reg >> VRAM_AW) == '0);

    assign ram_we     = clr_reg || (accept && (in_op == OP_WR_RAM));
    assign ram_addr   = clr_reg ? clr_cnt_reg : ram_idx;
    assign ram_wdata  = clr_reg ? 8'd0 : in_wdata;
    assign vram_we    = vram_clr || (accept && (in_op == OP_WR_VRAM));
    assign vram_addr  = clr_reg ? clr_cnt_reg[VRAM_AW-1:0] : vram_idx;
    assign vram_wdata = clr_reg ? 8'd0 : in_wdata;

    abdsl_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
        .aclk  (aclk),
        .we    (accept && (in_op == OP_LD_ROM)),
        .re    (accept && (in_op == OP_RD_ROM)),
        .addr  (rom_idx),
        .wdata (in_wdata),
        .rdata (rom_rdata)
    );

    abdsl_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_work_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (accept && (in_op == OP_RD_RAM)),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    abdsl_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_video_ram (
        .aclk  (aclk),
        .we    (vram_we),
        .re    (accept && (in_op == OP_RD_VRAM)),
        .addr  (vram_addr),
        .wdata (vram_wdata),
        .rdata (vram_rdata)
    );

    // -------------------------------------------------------- access stage
    logic       s1_valid_reg;
    op_t        s1_op_reg;
    logic [7:0] s1_data_reg;
    logic [4:0] s1_port1_reg;
    logic [7:0] s1_port2_reg;
    logic [7:0] s1_sys_reg;
    logic       out_adv;
    logic       s1_adv;

    assign out_adv  = !m_tvalid || m_tready;
    assign s1_adv   = s1_valid_reg && out_adv;
    assign s_tready = !clr_reg && (!s1_valid_reg || out_adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg    <= in_op;
            s1_data_reg  <= in_wdata;
            s1_port1_reg <= s_tdata[28:24];
            s1_port2_reg <= s_tdata[36:29];
            s1_sys_reg   <= s_tdata[44:37];
        end
    end

    snd_res_t snd_res;

    abdsl_sound u_sound (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (s1_adv),
        .op      (s1_op_reg),
        .data    (s1_data_reg),
        .res     (snd_res)
    );

    logic [7:0] rd_byte;

    always_comb begin
        unique case (s1_op_reg)
            OP_RD_ROM:    rd_byte = rom_rdata;
            OP_RD_RAM:    rd_byte = ram_rdata;
            OP_RD_VRAM:   rd_byte = vram_rdata;
            OP_RD_PORT1:  rd_byte = {3'd0, s1_port1_reg};
            OP_RD_PORT2:  rd_byte = s1_port2_reg;
            OP_RD_SYSTEM: rd_byte = s1_sys_reg;
            OP_RD_DIP:    rd_byte = dip_reg;
            default:      rd_byte = 8'd0;
        endcase
    end

    // ------------------------------------------------------ output register
    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= {7'd0, snd_res.irq, snd_res.tune_loop, snd_res.tune,
                           snd_res.effect, rd_byte};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: rtl/abdsl_ram.sv
// ============================================================================
// abdsl_ram
// Generic single-port RAM, one access a cycle, registered read data.
// ============================================================================
module abdsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        // read data holds until the next read
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/abdsl_decode.sv
// ============================================================================
// abdsl_decode
// Address and mode decode of one bus access, with memory indices.
// ============================================================================
module abdsl_decode
    import abdsl_pkg::*;
#(
    parameter int ROM_DEPTH = 16384,
    parameter int RAM_DEPTH = 4096,
    parameter int ROM_AW    = $clog2(ROM_DEPTH),
    parameter int RAM_AW    = $clog2(RAM_DEPTH)
) (
    input  logic [1:0]         mode,
    input  logic [15:0]        address,
    output op_t                op,
    output logic [ROM_AW-1:0]  rom_idx,
    output logic [RAM_AW-1:0]  ram_idx,
    output logic [VRAM_AW-1:0] vram_idx
);

    localparam int WIN_AW    = $clog2(RAM_WINDOW);
    localparam int RAM_FOLDS = (RAM_WINDOW + RAM_DEPTH - 1) / RAM_DEPTH - 1;

    logic              in_rom;
    logic              in_ram;
    logic              in_vram;
    logic [WIN_AW-1:0] ram_off;
    logic [WIN_AW:0]   ram_red;

    assign in_rom  = address < 16'(ROM_DEPTH);
    assign in_ram  = (address >= ADDR_RAM_LO) && (address < ADDR_RAM_HI);
    assign in_vram = (address >= ADDR_VRAM_LO) && (address < ADDR_VRAM_HI);

    assign ram_off = WIN_AW'(address - ADDR_RAM_LO);

    // mirror the window into the RAM: at most RAM_FOLDS conditional subtracts
    always_comb begin
        ram_red = {1'b0, ram_off};
        for (int i = 0; i < RAM_FOLDS; i++) begin
            if (ram_red >= (WIN_AW+1)'(RAM_DEPTH)) begin
                ram_red = ram_red - (WIN_AW+1)'(RAM_DEPTH);
            end
        end
    end

    assign rom_idx  = address[ROM_AW-1:0];
    assign ram_idx  = ram_red[RAM_AW-1:0];
    assign vram_idx = VRAM_AW'(address - ADDR_VRAM_LO);

    always_comb begin
        op = OP_NONE;
        unique case (mode)
            MODE_READ: begin
                priority if (in_rom)                  op = OP_RD_ROM;
                else if (in_ram)                      op = OP_RD_RAM;
                else if (in_vram)                     op = OP_RD_VRAM;
                else if (address == ADDR_LATCH)       op = OP_RD_PORT1;
                else if (address == ADDR_PORT2)       op = OP_RD_PORT2;
                else if (address == ADDR_SYSTEM)      op = OP_RD_SYSTEM;
                else if (address == ADDR_DIP)         op = OP_RD_DIP;
                else                                  op = OP_NONE;
            end
            MODE_WRITE: begin
                priority if (in_ram)                  op = OP_WR_RAM;
                else if (in_vram)                     op = OP_WR_VRAM;
                else if (address == ADDR_LATCH)       op = OP_WR_LATCH;
                else if (address == ADDR_JUMP)        op = OP_WR_JUMP;
                else if (address == ADDR_BOOM)        op = OP_WR_BOOM;
                else if (address == ADDR_SPRING)      op = OP_WR_SPRING;
                else if (address == ADDR_FALL)        op = OP_WR_FALL;
                else if (address == ADDR_SCORE)       op = OP_WR_SCORE;
                else if (address == ADDR_DIP)         op = OP_WR_DEATH;
                else if (address == ADDR_IRQ)         op = OP_WR_IRQ;
                else                                  op = OP_NONE;
            end
            MODE_LOAD: begin
                op = in_rom ? OP_LD_ROM : OP_NONE;
            end
            default: op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/abdsl_sound.sv
// ============================================================================
// abdsl_sound
// Sound latch, effect flags, current tune and vblank interrupt enable.
// ============================================================================
module abdsl_sound
    import abdsl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  op_t        op,
    input  logic [7:0] data,
    output snd_res_t   res
);

    logic [6:0] flags_reg, flags_next;
    logic [3:0] tune_reg, tune_next;
    logic       irq_reg, irq_next;

    logic [2:0] fx_code;
    logic       fx_we;
    logic [3:0] cmd_tune;
    logic       cmd_en;
    logic       clr_hr;
    logic [2:0] fx_bit;
    logic [2:0] fx_out;
    logic [3:0] tune_out;
    logic       data_nz;

    assign data_nz = data != 8'd0;
    assign fx_bit  = 3'(fx_code - 3'd1);

    always_comb begin
        fx_code  = FX_NONE;
        fx_we    = 1'b0;
        cmd_tune = TUNE_NONE;
        cmd_en   = 1'b0;
        clr_hr   = 1'b0;
        irq_next = irq_reg;
        unique case (op)
            OP_WR_LATCH: begin
                priority if (data == LATCH_STOP) begin
                    clr_hr = 1'b1;
                end else if (data == LATCH_HAMMER) begin
                    fx_code = FX_HAMMER;
                    fx_we   = 1'b1;
                end else if (data == LATCH_RIVET) begin
                    fx_code = FX_RIVET;
                    fx_we   = 1'b1;
                end else begin
                    cmd_tune = latch_tune(data);
                    cmd_en   = cmd_tune != TUNE_NONE;
                end
            end
            OP_WR_JUMP:   begin fx_code = FX_JUMP;   fx_we = 1'b1; end
            OP_WR_BOOM:   begin fx_code = FX_BOOM;   fx_we = 1'b1; end
            OP_WR_SPRING: begin fx_code = FX_SPRING; fx_we = 1'b1; end
            OP_WR_FALL:   begin fx_code = FX_FALL;   fx_we = 1'b1; end
            OP_WR_SCORE:  begin fx_code = FX_SCORE;  fx_we = 1'b1; end
            OP_WR_DEATH: begin
                cmd_tune = TUNE_DEATH;
                cmd_en   = data_nz;
            end
            OP_WR_IRQ: irq_next = data_nz;
            default: ;
        endcase
    end

    always_comb begin
        flags_next = flags_reg;
        tune_next  = tune_reg;
        fx_out     = FX_NONE;
        tune_out   = TUNE_NONE;
        if (fx_we) begin
            // starts only on a zero-to-nonzero change of the flag
            if (data_nz && !flags_reg[fx_bit]) begin
                fx_out = fx_code;
            end
            flags_next[fx_bit] = data_nz;
        end
        if (clr_hr || cmd_en) begin
            flags_next[FX_HAMMER - 3'd1] = 1'b0;
            flags_next[FX_RIVET - 3'd1]  = 1'b0;
        end
        // low time does not override the death tune
        if (cmd_en && (cmd_tune != tune_reg)
                && !((tune_reg == TUNE_DEATH) && (cmd_tune == TUNE_LOWTIME))) begin
            tune_next = cmd_tune;
            tune_out  = cmd_tune;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            tune_reg  <= TUNE_NONE;
            irq_reg   <= 1'b0;
        end else if (fire) begin
            flags_reg <= flags_next;
            tune_reg  <= tune_next;
            irq_reg   <= irq_next;
        end
    end

    assign res.effect    = fx_out;
    assign res.tune      = tune_out;
    assign res.tune_loop = (tune_out != TUNE_NONE) && tune_repeats(tune_out);
    assign res.irq       = irq_next;

endmodule

FILE: test/arcade_bus_decoder_sound_latch_core_test.sv
// ============================================================================
// arcade_bus_decoder_sound_latch_core_test
// Sends bus reads, writes and ROM preloads to the decoder core. A model of
// the memories, the sound latch and the effect flags, kept in this bench,
// predicts each result, and every result is compared field by field.
// ============================================================================
module arcade_bus_decoder_sound_latch_core_test;
    import abdsl_pkg::*;

    localparam int ROM_WORDS = 16384;
    localparam int RAM_WORDS = 4096;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [4:0]  player_port;
        logic [7:0]  second_port;
        logic [7:0]  system_port;
    } access_t;

    // m_tdata[16:0], lowest field last
    typedef struct packed {
        logic       irq;
        logic       tune_loop;
        logic [3:0] tune;
        logic [2:0] effect;
        logic [7:0] read_data;
    } reply_t;

    class sound_bus_tracker;
        logic [7:0] rom [ROM_WORDS];
        bit [7:0]   ram [RAM_WORDS];
        bit [7:0]   vram [VRAM_DEPTH];
        bit [6:0]   fx_flags;
        bit [3:0]   tune_now;
        bit         irq_on;
        bit [7:0]   dip;
        bit [3:0]   latch_to_tune [16];
        bit [15:0]  loop_mask;
        reply_t     pending_replies [$];
        int         errors;
        int         checked;
        int         effects_started;
        int         tunes_started;

        function new();
            dip = DIP_RESET;
            latch_to_tune = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd12, 4'd0, 4'd10,
                              4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd0, 4'd13, 4'd0};
            loop_mask = 16'h03f0;   // stage tunes 4..9 repeat
        endfunction

        function void set_dip(bit [7:0] value);
            dip = value;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void drop_stage_effects();
            fx_flags[FX_HAMMER - 1] = 1'b0;
            fx_flags[FX_RIVET - 1]  = 1'b0;
        endfunction

        // flag follows the data; an effect fires only on a rising flag
        function logic [2:0] raise_effect(logic [2:0] code, logic [7:0] data);
            logic [2:0] started;
            started = (data != 8'd0 && !fx_flags[code - 1]) ? code : FX_NONE;
            fx_flags[code - 1] = (data != 8'd0);
            return started;
        endfunction

        function logic [3:0] command_tune(logic [3:0] tune);
            drop_stage_effects();
            if (tune == tune_now)
                return TUNE_NONE;
            if (tune_now == TUNE_DEATH && tune == TUNE_LOWTIME)
                return TUNE_NONE;
            tune_now = tune;
            return tune;
        endfunction

        function void note_access(access_t a);
            reply_t     r;
            logic [7:0] d;
            r = '0;
            d = a.write_data;
            case (a.mode)
                MODE_READ: begin
                    if (a.address < ROM_WORDS)
                        r.read_data = rom[a.address];
                    else if (a.address >= ADDR_RAM_LO && a.address < ADDR_RAM_HI)
                        r.read_data = ram[(a.address - ADDR_RAM_LO) % RAM_WORDS];
                    else if (a.address >= ADDR_VRAM_LO && a.address < ADDR_VRAM_HI)
                        r.read_data = vram[(a.address - ADDR_VRAM_LO) % VRAM_DEPTH];
                    else if (a.address == ADDR_LATCH)
                        r.read_data = {3'b000, a.player_port};
                    else if (a.address == ADDR_PORT2)
                        r.read_data = a.second_port;
                    else if (a.address == ADDR_SYSTEM)
                        r.read_data = a.system_port;
                    else if (a.address == ADDR_DIP)
                        r.read_data = dip;
                end
                MODE_WRITE: begin
                    if (a.address >= ADDR_RAM_LO && a.address < ADDR_RAM_HI) begin
                        ram[(a.address - ADDR_RAM_LO) % RAM_WORDS] = d;
                    end else if (a.address >= ADDR_VRAM_LO && a.address < ADDR_VRAM_HI) begin
                        vram[(a.address - ADDR_VRAM_LO) % VRAM_DEPTH] = d;
                    end else begin
                        case (a.address)
                            ADDR_LATCH: begin
                                if (d == LATCH_STOP)
                                    drop_stage_effects();
                                else if (d == LATCH_HAMMER)
                                    r.effect = raise_effect(FX_HAMMER, d);
                                else if (d == LATCH_RIVET)
                                    r.effect = raise_effect(FX_RIVET, d);
                                else if (d < 8'd16 && latch_to_tune[d[3:0]] != TUNE_NONE)
                                    r.tune = command_tune(latch_to_tune[d[3:0]]);
                            end
                            ADDR_JUMP:   r.effect = raise_effect(FX_JUMP, d);
                            ADDR_BOOM:   r.effect = raise_effect(FX_BOOM, d);
                            ADDR_SPRING: r.effect = raise_effect(FX_SPRING, d);
                            ADDR_FALL:   r.effect = raise_effect(FX_FALL, d);
                            ADDR_SCORE:  r.effect = raise_effect(FX_SCORE, d);
                            ADDR_DIP: begin
                                if (d != 8'd0)
                                    r.tune = command_tune(TUNE_DEATH);
                            end
                            ADDR_IRQ:    irq_on = (d != 8'd0);
                            default: ;
                        endcase
                    end
                end
                MODE_LOAD: begin
                    if (a.address < ROM_WORDS)
                        rom[a.address] = d;
                end
                default: ;
            endcase
            r.tune_loop = loop_mask[r.tune];
            r.irq = irq_on;
            if (r.effect != FX_NONE)
                effects_started++;
            if (r.tune != TUNE_NONE)
                tunes_started++;
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [23:0] word);
            reply_t got;
            reply_t want;
            got = reply_t'(word[16:0]);
            if (pending_replies.size() == 0) begin
                $error("result 0x%h arrived with no access outstanding", word);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                checked++;
                if (got.read_data !== want.read_data) begin
                    $error("read_data: expected 0x%0h, got 0x%0h", want.read_data, got.read_data);
                    errors++;
                end
                if (got.effect !== want.effect) begin
                    $error("effect_start: expected %0d, got %0d", want.effect, got.effect);
                    errors++;
                end
                if (got.tune !== want.tune) begin
                    $error("tune_start: expected %0d, got %0d", want.tune, got.tune);
                    errors++;
                end
                if (got.tune_loop !== want.tune_loop) begin
                    $error("tune_loop: expected %0d, got %0d", want.tune_loop, got.tune_loop);
                    errors++;
                end
                if (got.irq !== want.irq) begin
                    $error("vblank_irq_enable: expected %0d, got %0d", want.irq, got.irq);
                    errors++;
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [47:0]       s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    sound_bus_tracker tracker;
    bit               rom_loaded_map [ROM_WORDS];
    logic [15:0]      rom_loaded_list [$];
    logic [7:0]       last_latch;
    bit               steady_flow;
    int               hold_cycles;
    int               dip_settings;

    arcade_bus_decoder_sound_latch_core #(
        .ROM_DEPTH(ROM_WORDS),
        .RAM_DEPTH(RAM_WORDS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic access_t build_access(logic [1:0] mode, logic [15:0] addr,
                                             logic [7:0] data);
        access_t a;
        a.mode        = mode;
        a.address     = addr;
        a.write_data  = data;
        a.player_port = 5'($urandom_range(0, 31));
        a.second_port = 8'($urandom_range(0, 255));
        a.system_port = 8'($urandom_range(0, 255));
        return a;
    endfunction

    // favors the window edges so boundary entries get reused
    function automatic logic [15:0] window_addr(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(0, 3))
            0: return lo + 16'($urandom_range(0, 15));
            1: return hi - 16'd1 - 16'($urandom_range(0, 15));
            default: return lo + 16'($urandom_range(0, int'(hi - lo) - 1));
        endcase
    endfunction

    task automatic post_access(input access_t a);
        int gap;
        gap = pick_gap();
        // never read ROM bytes that were not preloaded
        if (a.mode == MODE_READ && a.address < ROM_WORDS && !rom_loaded_map[a.address])
            a.address = a.address | 16'h8000;
        if (a.mode == MODE_LOAD && a.address < ROM_WORDS && !rom_loaded_map[a.address]) begin
            rom_loaded_map[a.address] = 1'b1;
            rom_loaded_list.push_back(a.address);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = a.mode;
        s_tdata  = {3'b000, a.system_port, a.second_port, a.player_port,
                    a.write_data, a.address};
        do @(posedge aclk); while (!s_tready);
        tracker.note_access(a);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_dip_switches(input logic [7:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_AW'(4 * CFG_DIP_SWITCHES);
        pwdata  = {24'd0, value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_dip(value);
        dip_settings++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_directed();
        access_t a;
        post_access(build_access(MODE_LOAD, 16'h0000, 8'hff));
        post_access(build_access(MODE_LOAD, 16'(ROM_WORDS - 1), 8'h81));
        post_access(build_access(MODE_LOAD, 16'hffff, 8'h55));   // beyond ROM, dropped
        post_access(build_access(MODE_READ, 16'h0000, 8'h00));
        post_access(build_access(MODE_READ, 16'(ROM_WORDS - 1), 8'hff));
        post_access(build_access(MODE_READ, 16'hffff, 8'h00));
        post_access(build_access(MODE_WRITE, ADDR_RAM_HI - 16'd1, 8'hff));
        post_access(build_access(MODE_READ, ADDR_RAM_HI - 16'd1, 8'h00));
        post_access(build_access(MODE_READ, ADDR_RAM_LO, 8'h00));
        post_access(build_access(MODE_WRITE, ADDR_VRAM_LO, 8'h42));
        post_access(build_access(MODE_READ, ADDR_VRAM_HI - 16'd1, 8'h00));
        a = build_access(MODE_READ, ADDR_LATCH, 8'h00);
        a.player_port = '1;
        a.second_port = '1;
        a.system_port = '1;
        post_access(a);
        a.address = ADDR_PORT2;
        post_access(a);
        a.address = ADDR_SYSTEM;
        post_access(a);
        a.address = ADDR_DIP;
        post_access(a);
        post_access(build_access(MODE_WRITE, ADDR_LATCH, LATCH_HAMMER));
        post_access(build_access(MODE_WRITE, ADDR_LATCH, LATCH_RIVET));
        post_access(build_access(MODE_WRITE, ADDR_LATCH, 8'd14));   // tune clears both
        post_access(build_access(MODE_WRITE, ADDR_LATCH, 8'd8));    // looping tune
        post_access(build_access(MODE_WRITE, ADDR_DIP, 8'h00));     // zero: no death tune
        post_access(build_access(MODE_WRITE, ADDR_DIP, 8'h80));
        post_access(build_access(MODE_WRITE, ADDR_LATCH, 8'd3));    // low time after death
        post_access(build_access(MODE_WRITE, ADDR_BOOM, 8'h01));
        post_access(build_access(MODE_WRITE, ADDR_BOOM, 8'hff));    // flag already up
        post_access(build_access(MODE_WRITE, ADDR_LATCH, 8'hff));
        post_access(build_access(MODE_WRITE, ADDR_IRQ, 8'h01));
        post_access(build_access(MODE_UNUSED, ADDR_IRQ, 8'h00));
    endtask

    task automatic post_random_access();
        access_t a;
        int      pick;
        a = build_access(MODE_READ, 16'h0000, 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            a.mode = MODE_WRITE;
            a.address = window_addr(ADDR_RAM_LO, ADDR_RAM_HI);
        end else if (pick < 22) begin
            a.address = window_addr(ADDR_RAM_LO, ADDR_RAM_HI);
        end else if (pick < 28) begin
            a.mode = MODE_WRITE;
            a.address = window_addr(ADDR_VRAM_LO, ADDR_VRAM_HI);
        end else if (pick < 34) begin
            a.address = window_addr(ADDR_VRAM_LO, ADDR_VRAM_HI);
        end else if (pick < 42) begin
            a.mode = MODE_LOAD;
            if ($urandom_range(0, 9) == 0)
                a.address = 16'($urandom_range(ROM_WORDS, 16'hffff));
            else if ($urandom_range(0, 1) == 0)
                a.address = 16'($urandom_range(0, 63));
            else
                a.address = 16'($urandom_range(0, ROM_WORDS - 1));
        end else if (pick < 50) begin
            if (rom_loaded_list.size() != 0)
                a.address = rom_loaded_list[$urandom_range(0, rom_loaded_list.size() - 1)];
            else
                a.address = ADDR_DIP;
        end else if (pick < 68) begin
            // latch commands: repeats matter as much as changes
            a.mode = MODE_WRITE;
            a.address = ADDR_LATCH;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: a.write_data = last_latch;
                4:          a.write_data = 8'($urandom_range(0, 255));
                default:    a.write_data = 8'($urandom_range(0, 15));
            endcase
            last_latch = a.write_data;
        end else if (pick < 78) begin
            a.mode = MODE_WRITE;
            a.address = ADDR_JUMP + 16'($urandom_range(0, 4));
            if ($urandom_range(0, 1) == 0)
                a.write_data = 8'h00;
        end else if (pick < 82) begin
            a.mode = MODE_WRITE;
            a.address = ADDR_DIP;
            if ($urandom_range(0, 3) == 0)
                a.write_data = 8'h00;
            post_access(a);
            // low time right after a death
            a = build_access(MODE_WRITE, ADDR_LATCH, 8'd3);
        end else if (pick < 86) begin
            a.mode = MODE_WRITE;
            a.address = ADDR_IRQ;
            if ($urandom_range(0, 1) == 0)
                a.write_data = 8'h00;
        end else if (pick < 92) begin
            case ($urandom_range(0, 3))
                0: a.address = ADDR_LATCH;
                1: a.address = ADDR_PORT2;
                2: a.address = ADDR_SYSTEM;
                default: a.address = ADDR_DIP;
            endcase
        end else begin
            a.mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: a.address = ADDR_RAM_LO - 16'd1;
                1: a.address = ADDR_VRAM_LO - 16'd1;
                2: a.address = ADDR_VRAM_HI;
                3: a.address = ADDR_LATCH + 16'd1;
                4: a.address = ADDR_SCORE + 16'd1;
                5: a.address = ADDR_IRQ + 16'd1;
                default: a.address = 16'($urandom_range(0, 16'hffff));
            endcase
        end
        post_access(a);
    endtask

    task automatic random_run(input int count);
        repeat (count) post_random_access();
    endtask

    // result side: random back-pressure, plus a long hold when asked
    initial begin : result_sink
        int stall_left;
        int g;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                g = pick_gap();
                m_tready = (g == 0);
                stall_left = (g > 0) ? g - 1 : 0;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready)
                tracker.check_reply(m_tdata);
        end
    end

    initial begin
        #5_000_000;
        $display("arcade_bus_decoder_sound_latch_core_test: errors");
        $finish;
    end

    initial begin
        tracker = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_READ;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        last_latch  = 8'd0;
        steady_flow = 1'b0;
        hold_cycles = 0;
        dip_settings = 1;   // reset value counts as the first setting
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();

        drain_results();
        set_dip_switches(8'h00);
        random_run(150);

        // back-to-back on both sides
        drain_results();
        set_dip_switches(8'hff);
        steady_flow = 1'b1;
        random_run(150);
        steady_flow = 1'b0;

        // long output stall while items keep coming
        drain_results();
        set_dip_switches(8'($urandom_range(1, 254)));
        hold_cycles = 400;
        random_run(150);

        drain_results();
        set_dip_switches(DIP_RESET);
        random_run(100);

        drain_results();
        repeat (8) @(posedge aclk);
        $display("checked %0d bus accesses under %0d DIP settings", tracker.checked,
                 dip_settings);
        $display("%0d effects and %0d tunes started, %0d ROM bytes preloaded",
                 tracker.effects_started, tracker.tunes_started, rom_loaded_list.size());
        if (tracker.errors == 0) begin
            $display("arcade_bus_decoder_sound_latch_core_test: clean");
        end else begin
            $display("arcade_bus_decoder_sound_latch_core_test: errors");
        end
        $finish;
    end

endmodule
